// ----- src/nta_pkg.sv -----
// Shared types and constants for the neighbor table with aging.
package nta_pkg;

   // Field widths of the channels
   localparam int MODE_W      = 3;
   localparam int NODE_ID_W   = 16;
   localparam int STATUS_W    = 2;
   localparam int COUNT_W     = 5;
   localparam int TIMEOUT_W   = 16;
   localparam int TIME_W      = 32;

   localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 16'd3000;

   // Operation codes carried in the mode field
   typedef enum logic [MODE_W-1:0] {
      MODE_ADD     = 3'd0,
      MODE_DEL     = 3'd1,
      MODE_FIND    = 3'd2,
      MODE_REFRESH = 3'd3,
      MODE_TICK    = 3'd4,
      MODE_FLUSH   = 3'd5
   } mode_type;

   // Result codes
   typedef enum logic [STATUS_W-1:0] {
      STS_OK        = 2'd0,
      STS_MISSING   = 2'd1,
      STS_DUPLICATE = 2'd2,
      STS_FULL      = 2'd3
   } status_type;

   // Sequencer states
   typedef enum logic [1:0] {
      S_IDLE   = 2'd0,
      S_WALK   = 2'd1,
      S_DRAIN  = 2'd2,
      S_COMMIT = 2'd3
   } state_type;

   // Controller to datapath commands
   typedef struct packed {
      logic load;     // capture the request beat, restart the walk
      logic issue;    // read the entry at the walk index, advance it
      logic commit;   // apply the operation, load the result register
   } nta_cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic walk_last;  // walk index points at the last entry
      logic out_free;   // result register can take a new beat
   } nta_sts_type;

endpackage

// ----- src/nta_if.sv -----
// Channel interfaces: request, response and configuration write.
interface nta_req_if import nta_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [MODE_W-1:0]    mode;
   logic [NODE_ID_W-1:0] node_id;

   modport source (output valid, output mode, output node_id, input ready);
   modport sink   (input valid, input mode, input node_id, output ready);
endinterface

interface nta_rsp_if import nta_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [COUNT_W-1:0]  entry_count;
   logic [COUNT_W-1:0]  expired_count;

   modport source (output valid, output status, output entry_count,
                   output expired_count, input ready);
   modport sink   (input valid, input status, input entry_count,
                   input expired_count, output ready);
endinterface

interface nta_csr_if import nta_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [TIMEOUT_W-1:0] timeout_ticks;

   modport source (output valid, output timeout_ticks, input ready);
   modport sink   (input valid, input timeout_ticks, output ready);
endinterface

// ----- src/nta_ctrl.sv -----
// Sequencer for the neighbor table: accept, walk, drain, commit.
module nta_ctrl import nta_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  nta_sts_type sts,
   output nta_cmd_type cmd
);

   state_type state_ff;
   state_type state_in;

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and commands
   always_comb begin
      state_in   = state_ff;
      req_ready  = 1'b0;
      cmd.load   = 1'b0;
      cmd.issue  = 1'b0;
      cmd.commit = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_WALK;
            end
         end
         S_WALK: begin
            cmd.issue = 1'b1;
            if (sts.walk_last) begin
               state_in = S_DRAIN;
            end
         end
         S_DRAIN: begin
            // last entry read is checked this cycle
            state_in = S_COMMIT;
         end
         S_COMMIT: begin
            // wait until the previous result beat has left
            if (sts.out_free) begin
               cmd.commit = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

`ifndef SYNTHESIS
   // A commit held back by a stalled receiver stays pending
   a_commit_holds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_COMMIT && !sts.out_free) |=> (state_ff == S_COMMIT))
      else $error("commit dropped while result register busy");
`endif

endmodule

// ----- src/nta_dpath.sv -----
// Datapath: entry store, walk pipeline, time base and result register.
module nta_dpath import nta_pkg::*; #(
   parameter int TABLE_ENTRIES = 16,
   parameter int ID_BITS       = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  nta_cmd_type          cmd,
   output nta_sts_type          sts,
   input  logic [MODE_W-1:0]    req_mode,
   input  logic [NODE_ID_W-1:0] req_node_id,
   input  logic                 csr_write,
   input  logic [TIMEOUT_W-1:0] csr_timeout,
   input  logic                 rsp_ready,
   output logic                 rsp_valid,
   output logic [STATUS_W-1:0]  rsp_status,
   output logic [COUNT_W-1:0]   rsp_entry_count,
   output logic [COUNT_W-1:0]   rsp_expired_count
);

   localparam int IW = $clog2(TABLE_ENTRIES);
   localparam int CW = $clog2(TABLE_ENTRIES + 1);

   // Entry store (ident and deadline are unset until written)
   logic [ID_BITS-1:0]       ident_mem [TABLE_ENTRIES];
   logic [TIME_W-1:0]        dl_mem    [TABLE_ENTRIES];
   logic [TABLE_ENTRIES-1:0] valid_ff;
   logic [CW-1:0]            cnt_ff;

   // Time base and timeout register
   logic [TIME_W-1:0]    time_ff;
   logic [TIMEOUT_W-1:0] timeout_ff;

   // Captured request
   mode_type          mode_ff;
   logic [ID_BITS-1:0] key_ff;
   logic [TIME_W-1:0] dl_new_ff;
   logic [TIME_W-1:0] now_next_ff;
   logic [2*NODE_ID_W-1:0] id_wide;

   // Walk pipeline
   logic [IW-1:0]      walk_idx_ff;
   logic               chk_vld_ff;
   logic [IW-1:0]      chk_idx_ff;
   logic [ID_BITS-1:0] ident_rd_ff;
   logic [TIME_W-1:0]  dl_rd_ff;

   // Walk results
   logic          found_ff;
   logic [IW-1:0] match_idx_ff;
   logic          free_found_ff;
   logic [IW-1:0] free_idx_ff;
   logic [CW-1:0] exp_cnt_ff;

   // Result register
   logic                rsp_valid_ff;
   status_type          rsp_status_ff;
   logic [COUNT_W-1:0]  rsp_cnt_ff;
   logic [COUNT_W-1:0]  rsp_exp_ff;

   // Check stage and commit decode
   logic          hit;
   logic          empty;
   logic          expire;
   status_type    status_in;
   logic [CW-1:0] cnt_in;
   logic [CW-1:0] exp_in;
   logic          wr_ident;
   logic          wr_dl;
   logic [IW-1:0] wr_idx;
   logic          set_v;
   logic          clr_v;
   logic          clr_all;
   logic          tick_adv;

   assign id_wide = {{NODE_ID_W{1'b0}}, req_node_id};

   assign sts.walk_last = (walk_idx_ff == IW'(TABLE_ENTRIES - 1));
   assign sts.out_free  = !rsp_valid_ff || rsp_ready;

   // Check stage: one entry per cycle
   assign hit    = chk_vld_ff && valid_ff[chk_idx_ff] && (ident_rd_ff == key_ff);
   assign empty  = chk_vld_ff && !valid_ff[chk_idx_ff];
   assign expire = chk_vld_ff && (mode_ff == MODE_TICK) && valid_ff[chk_idx_ff]
                   && (dl_rd_ff == now_next_ff);

   // Timeout register and time base
   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff <= TIMEOUT_RESET;
         time_ff    <= '0;
      end else begin
         if (csr_write) begin
            timeout_ff <= csr_timeout;
         end
         if (cmd.commit && tick_adv) begin
            time_ff <= now_next_ff;
         end
      end
   end

   // Request capture; deadline and next time precomputed
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         mode_ff     <= mode_type'(req_mode);
         key_ff      <= id_wide[ID_BITS-1:0];
         dl_new_ff   <= time_ff + TIME_W'(timeout_ff);
         now_next_ff <= time_ff + TIME_W'(1);
      end
   end

   // Walk index and check-stage valid
   always_ff @(posedge clock) begin
      if (reset) begin
         walk_idx_ff <= '0;
         chk_vld_ff  <= 1'b0;
      end else begin
         chk_vld_ff <= cmd.issue;
         if (cmd.load) begin
            walk_idx_ff <= '0;
         end else if (cmd.issue) begin
            walk_idx_ff <= walk_idx_ff + IW'(1);
         end
      end
   end

   // Store read port, registered
   always_ff @(posedge clock) begin
      if (cmd.issue) begin
         ident_rd_ff <= ident_mem[walk_idx_ff];
         dl_rd_ff    <= dl_mem[walk_idx_ff];
         chk_idx_ff  <= walk_idx_ff;
      end
   end

   // Store write port
   always_ff @(posedge clock) begin
      if (cmd.commit && wr_ident) begin
         ident_mem[wr_idx] <= key_ff;
      end
      if (cmd.commit && wr_dl) begin
         dl_mem[wr_idx] <= dl_new_ff;
      end
   end

   // Walk results: first match, lowest free slot, expirations
   always_ff @(posedge clock) begin
      if (reset) begin
         found_ff      <= 1'b0;
         free_found_ff <= 1'b0;
         exp_cnt_ff    <= '0;
      end else if (cmd.load) begin
         found_ff      <= 1'b0;
         free_found_ff <= 1'b0;
         exp_cnt_ff    <= '0;
      end else begin
         if (hit && !found_ff) begin
            found_ff     <= 1'b1;
            match_idx_ff <= chk_idx_ff;
         end
         if (empty && !free_found_ff) begin
            free_found_ff <= 1'b1;
            free_idx_ff   <= chk_idx_ff;
         end
         if (expire) begin
            exp_cnt_ff <= exp_cnt_ff + CW'(1);
         end
      end
   end

   // Commit decode
   always_comb begin
      status_in = STS_OK;
      cnt_in    = cnt_ff;
      exp_in    = '0;
      wr_ident  = 1'b0;
      wr_dl     = 1'b0;
      wr_idx    = free_idx_ff;
      set_v     = 1'b0;
      clr_v     = 1'b0;
      clr_all   = 1'b0;
      tick_adv  = 1'b0;
      case (mode_ff)
         MODE_ADD: begin
            // duplicate wins over full
            if (found_ff) begin
               status_in = STS_DUPLICATE;
            end else if (!free_found_ff) begin
               status_in = STS_FULL;
            end else begin
               wr_ident = 1'b1;
               wr_dl    = 1'b1;
               set_v    = 1'b1;
               cnt_in   = cnt_ff + CW'(1);
            end
         end
         MODE_DEL: begin
            wr_idx = match_idx_ff;
            if (found_ff) begin
               clr_v  = 1'b1;
               cnt_in = cnt_ff - CW'(1);
            end else begin
               status_in = STS_MISSING;
            end
         end
         MODE_FIND: begin
            if (!found_ff) begin
               status_in = STS_MISSING;
            end
         end
         MODE_REFRESH: begin
            wr_idx = match_idx_ff;
            if (found_ff) begin
               wr_dl = 1'b1;
            end else begin
               status_in = STS_MISSING;
            end
         end
         MODE_TICK: begin
            // expired entries were cleared during the walk
            tick_adv = 1'b1;
            cnt_in   = cnt_ff - exp_cnt_ff;
            exp_in   = exp_cnt_ff;
         end
         MODE_FLUSH: begin
            clr_all = 1'b1;
            cnt_in  = '0;
         end
         default: begin
         end
      endcase
   end

   // Valid bits and entry count
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         cnt_ff   <= '0;
      end else begin
         if (expire) begin
            valid_ff[chk_idx_ff] <= 1'b0;
         end
         if (cmd.commit) begin
            cnt_ff <= cnt_in;
            if (clr_all) begin
               valid_ff <= '0;
            end else if (set_v) begin
               valid_ff[free_idx_ff] <= 1'b1;
            end else if (clr_v) begin
               valid_ff[match_idx_ff] <= 1'b0;
            end
         end
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.commit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         rsp_status_ff <= status_in;
         rsp_cnt_ff    <= COUNT_W'(cnt_in);
         rsp_exp_ff    <= COUNT_W'(exp_in);
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_entry_count   = rsp_cnt_ff;
   assign rsp_expired_count = rsp_exp_ff;

`ifndef SYNTHESIS
   // Entry count never exceeds the table size
   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      (int'(cnt_ff) <= TABLE_ENTRIES))
      else $error("entry count beyond table size");

   // After a commit the count agrees with the valid bits
   a_cnt_match: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |=> ($countones(valid_ff) == int'(cnt_ff)))
      else $error("entry count out of step with valid bits");

   // Full is reported only when every slot is taken
   a_full_real: assert property (@(posedge clock) disable iff (reset)
      (cmd.commit && status_in == STS_FULL) |-> ($countones(valid_ff) == TABLE_ENTRIES))
      else $error("table full reported with a free slot");
`endif

endmodule

// ----- src/neighbor_table_with_aging.sv -----
// Neighbor table with aging: top level.
//
// Usage:
//   req_bus carries one operation per beat: mode (add, delete, find,
//   refresh, tick, flush) and node_id. rsp_bus returns exactly one beat
//   per request: status, entry_count after the operation and, for tick,
//   the number of entries that expired. csr_bus writes timeout_ticks; it
//   is always ready and should be written only while no request is open.
//   Each request walks every table entry through the store's single read
//   port, one entry per cycle, then passes through a drain state and
//   commits. The response is registered at the commit, and a new request
//   is taken only in the idle state, once the previous request has been
//   committed; requests are not overlapped.
//   A finished response sits in an output register, so the next request is
//   accepted and walked while the receiver stalls; its commit waits until
//   the earlier response beat has been taken.
//   Reset (synchronous) empties the table, zeroes the tick time and loads
//   the timeout with 3000.
module neighbor_table_with_aging import nta_pkg::*; #(
   parameter int TABLE_ENTRIES = 16,
   parameter int ID_BITS       = 16
) (
   input  logic       clock,
   input  logic       reset,
   nta_req_if.sink    req_bus,
   nta_rsp_if.source  rsp_bus,
   nta_csr_if.sink    csr_bus
);

   nta_cmd_type cmd;
   nta_sts_type sts;
   logic        req_ready;

   // Configuration writes are taken every cycle
   assign csr_bus.ready = 1'b1;
   assign req_bus.ready = req_ready;

   nta_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   nta_dpath #(
      .TABLE_ENTRIES (TABLE_ENTRIES),
      .ID_BITS       (ID_BITS)
   ) u_dpath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .sts               (sts),
      .req_mode          (req_bus.mode),
      .req_node_id       (req_bus.node_id),
      .csr_write         (csr_bus.valid),
      .csr_timeout       (csr_bus.timeout_ticks),
      .rsp_ready         (rsp_bus.ready),
      .rsp_valid         (rsp_bus.valid),
      .rsp_status        (rsp_bus.status),
      .rsp_entry_count   (rsp_bus.entry_count),
      .rsp_expired_count (rsp_bus.expired_count)
   );

endmodule

// ----- bench/nta_table_checker.sv -----
// Response checker for the neighbor table: tracks the table, predicts each response beat.
module nta_table_checker import nta_pkg::*; #(
   parameter int TABLE_ENTRIES = 16,
   parameter int ID_BITS       = 16
) (
   input  logic clock,
   input  logic reset,
   nta_req_if   req_mon,
   nta_rsp_if   rsp_mon,
   nta_csr_if   csr_mon,
   output int   failures,
   output int   pending,
   output int   responses_seen,
   output int   aged_out
);

   typedef struct packed {
      status_type         status;
      logic [COUNT_W-1:0] entry_count;
      logic [COUNT_W-1:0] expired_count;
   } rsp_beat_type;

   // Shadow copy of the table, the tick time and the timeout register
   logic                 slot_used     [TABLE_ENTRIES];
   logic [ID_BITS-1:0]   slot_id       [TABLE_ENTRIES];
   logic [TIME_W-1:0]    slot_deadline [TABLE_ENTRIES];
   logic [TIME_W-1:0]    tick_now;
   logic [TIMEOUT_W-1:0] timeout_ticks;

   rsp_beat_type expected_rsps[$];

   // Apply one request to the shadow table and return the beat it should produce
   function automatic rsp_beat_type table_apply(input logic [MODE_W-1:0]    mode,
                                                input logic [NODE_ID_W-1:0] node_id);
      logic [ID_BITS-1:0] ident;
      int                 hit;
      int                 free_slot;
      int                 used;
      rsp_beat_type       beat;
      ident     = ID_BITS'(node_id);
      hit       = -1;
      free_slot = -1;
      used      = 0;
      beat.status        = STS_OK;
      beat.expired_count = '0;
      for (int k = 0; k < TABLE_ENTRIES; k++) begin
         if (slot_used[k] && slot_id[k] == ident && hit < 0) hit = k;
         if (!slot_used[k] && free_slot < 0) free_slot = k;
      end
      case (mode)
         MODE_ADD: begin
            // duplicate wins over full
            if (hit >= 0) begin
               beat.status = STS_DUPLICATE;
            end else if (free_slot < 0) begin
               beat.status = STS_FULL;
            end else begin
               slot_used[free_slot]     = 1'b1;
               slot_id[free_slot]       = ident;
               slot_deadline[free_slot] = tick_now + TIME_W'(timeout_ticks);
            end
         end
         MODE_DEL: begin
            if (hit < 0) beat.status = STS_MISSING;
            else slot_used[hit] = 1'b0;
         end
         MODE_FIND: begin
            if (hit < 0) beat.status = STS_MISSING;
         end
         MODE_REFRESH: begin
            if (hit < 0) beat.status = STS_MISSING;
            else slot_deadline[hit] = tick_now + TIME_W'(timeout_ticks);
         end
         MODE_TICK: begin
            // time moves first, then entries due at the new time age out
            tick_now = tick_now + 1'b1;
            for (int k = 0; k < TABLE_ENTRIES; k++) begin
               if (slot_used[k] && slot_deadline[k] == tick_now) begin
                  slot_used[k] = 1'b0;
                  beat.expired_count = beat.expired_count + 1'b1;
               end
            end
         end
         MODE_FLUSH: begin
            for (int k = 0; k < TABLE_ENTRIES; k++) slot_used[k] = 1'b0;
         end
         default: ;  // unused modes leave everything alone
      endcase
      for (int k = 0; k < TABLE_ENTRIES; k++) used += slot_used[k];
      beat.entry_count = used[COUNT_W-1:0];
      return beat;
   endfunction

   // Compare response beats first, then take config and request beats of the same edge
   always @(posedge clock) begin
      rsp_beat_type want;
      if (reset) begin
         for (int k = 0; k < TABLE_ENTRIES; k++) begin
            slot_used[k]     = 1'b0;
            slot_id[k]       = '0;
            slot_deadline[k] = '0;
         end
         tick_now      = '0;
         timeout_ticks = TIMEOUT_RESET;
         expected_rsps.delete();
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            responses_seen++;
            if (expected_rsps.size() == 0) begin
               failures++;
               $error("response beat with no request outstanding: status %0d count %0d",
                      rsp_mon.status, rsp_mon.entry_count);
            end else begin
               want = expected_rsps.pop_front();
               if (rsp_mon.status !== want.status) begin
                  failures++;
                  $error("status: expected %0d, got %0d", want.status, rsp_mon.status);
               end
               if (rsp_mon.entry_count !== want.entry_count) begin
                  failures++;
                  $error("entry_count: expected %0d, got %0d",
                         want.entry_count, rsp_mon.entry_count);
               end
               if (rsp_mon.expired_count !== want.expired_count) begin
                  failures++;
                  $error("expired_count: expected %0d, got %0d",
                         want.expired_count, rsp_mon.expired_count);
               end
            end
         end
         if (csr_mon.valid && csr_mon.ready) timeout_ticks = csr_mon.timeout_ticks;
         if (req_mon.valid && req_mon.ready) begin
            want = table_apply(req_mon.mode, req_mon.node_id);
            aged_out += want.expired_count;
            expected_rsps.push_back(want);
         end
      end
      pending = expected_rsps.size();
   end

endmodule

// ----- bench/tb_neighbor_table_with_aging.sv -----
// Testbench top for the neighbor table: clock, reset, stimulus, stalls and verdict.
module tb_neighbor_table_with_aging;
   import nta_pkg::*;

   localparam int TABLE_ENTRIES  = 16;
   localparam int ID_BITS        = 16;
   localparam int RSP_LATENCY    = TABLE_ENTRIES + 3;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int LONG_HOLD      = 500;
   localparam int ID_POOL_SIZE   = 20;
   localparam int PHASE_COUNT    = 9;
   localparam int PHASE_ITEMS    = 115;
   localparam int HOLD_PHASE     = 3;

   // codes outside the defined operations
   localparam logic [MODE_W-1:0] MODE_UNUSED_LO = 3'd6;
   localparam logic [MODE_W-1:0] MODE_UNUSED_HI = 3'd7;

   logic clock;
   logic reset;

   nta_req_if req_bus ();
   nta_rsp_if rsp_bus ();
   nta_csr_if csr_bus ();

   int failures;
   int pending;
   int responses_seen;
   int aged_out;
   int idle_cycles;
   int burst_left;
   int settings_used;
   bit hold_request;

   logic [NODE_ID_W-1:0] id_pool      [ID_POOL_SIZE];
   logic [TIMEOUT_W-1:0] timeout_plan [PHASE_COUNT];

   neighbor_table_with_aging #(
      .TABLE_ENTRIES (TABLE_ENTRIES),
      .ID_BITS       (ID_BITS)
   ) dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   nta_table_checker #(
      .TABLE_ENTRIES (TABLE_ENTRIES),
      .ID_BITS       (ID_BITS)
   ) checker_i (
      .clock          (clock),
      .reset          (reset),
      .req_mon        (req_bus),
      .rsp_mon        (rsp_bus),
      .csr_mon        (csr_bus),
      .failures       (failures),
      .pending        (pending),
      .responses_seen (responses_seen),
      .aged_out       (aged_out)
   );

   // 8-unit clock
   always begin
      clock = 1'b0;
      #4;
      clock = 1'b1;
      #4;
   end

   // Watchdog: cycles in a row with no beat on any channel
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) ||
          (csr_bus.valid && csr_bus.ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog: no beat for %0d cycles, %0d responses outstanding",
                  idle_cycles, pending);
         $display("simulation failed");
         $finish;
      end
   end

   // Response side stalls: stretches of fixed patterns, plus one long hold on request
   initial begin
      int stretch;
      int pattern;
      rsp_bus.ready = 1'b0;
      @(negedge reset);
      forever begin
         if (hold_request) begin
            hold_request = 1'b0;
            for (int k = 0; k < LONG_HOLD; k++) begin
               rsp_bus.ready <= 1'b0;
               @(posedge clock);
            end
         end
         pattern = $urandom_range(0, 3);
         stretch = $urandom_range(20, 200);
         for (int k = 0; k < stretch && !hold_request; k++) begin
            case (pattern)
               0:       rsp_bus.ready <= 1'b1;                       // no stalls
               1:       rsp_bus.ready <= 1'($urandom_range(0, 1));   // coin flip
               2:       rsp_bus.ready <= (k % 4 == 3);               // one in four
               default: rsp_bus.ready <= ($urandom_range(0, 7) != 0);
            endcase
            @(posedge clock);
         end
      end
   end

   // Offer one request beat; the sender runs in bursts with random gaps between them.
   // Entered and left just after a rising edge.
   task automatic send_req(input logic [MODE_W-1:0] mode, input logic [NODE_ID_W-1:0] node_id);
      int gap;
      gap = 0;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         if ($urandom_range(0, 3) != 0) gap = $urandom_range(1, 30);
      end
      burst_left--;
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid   <= 1'b1;
      req_bus.mode    <= mode;
      req_bus.node_id <= node_id;
      do @(negedge clock); while (!req_bus.ready);
      @(posedge clock);
   endtask

   // Drop valid and wait until every response is back and the block has settled
   task automatic drain();
      req_bus.valid <= 1'b0;
      do @(negedge clock); while (pending != 0);
      repeat (RSP_LATENCY) @(posedge clock);
   endtask

   task automatic write_timeout(input logic [TIMEOUT_W-1:0] value);
      drain();
      csr_bus.valid         <= 1'b1;
      csr_bus.timeout_ticks <= value;
      do @(negedge clock); while (!csr_bus.ready);
      @(posedge clock);
      csr_bus.valid <= 1'b0;
      settings_used++;
   endtask

   function automatic logic [NODE_ID_W-1:0] pick_id();
      if ($urandom_range(0, 15) == 0) return NODE_ID_W'($urandom);
      return id_pool[$urandom_range(0, ID_POOL_SIZE - 1)];
   endfunction

   function automatic mode_type pick_mode();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 30) return MODE_ADD;
      if (roll < 45) return MODE_DEL;
      if (roll < 60) return MODE_FIND;
      if (roll < 75) return MODE_REFRESH;
      if (roll < 97) return MODE_TICK;
      return MODE_FLUSH;
   endfunction

   // Extremes, every operation, duplicate versus full, unused modes
   task automatic directed_items();
      send_req(MODE_TICK, '1);          // tick on an empty table
      send_req(MODE_ADD, '0);
      send_req(MODE_ADD, '0);           // duplicate
      send_req(MODE_ADD, '1);
      send_req(MODE_FIND, '1);
      send_req(MODE_REFRESH, '1);
      send_req(MODE_DEL, '0);
      send_req(MODE_DEL, '0);           // already gone
      send_req(MODE_UNUSED_LO, '1);
      send_req(MODE_UNUSED_HI, 16'h5a5a);
      for (int k = 1; k < TABLE_ENTRIES; k++) send_req(MODE_ADD, NODE_ID_W'(k));
      send_req(MODE_ADD, '1);           // duplicate on a full table
      send_req(MODE_ADD, 16'h8000);     // no free slot
      send_req(MODE_FLUSH, 16'h1234);
   endtask

   // Random phase: fill bursts, tick runs, mixed operations on a small id pool, some noise
   task automatic random_phase(input int n_items);
      int sent;
      int kind;
      int run_len;
      id_pool[0] = '0;
      id_pool[1] = '1;
      for (int k = 2; k < ID_POOL_SIZE; k++) id_pool[k] = NODE_ID_W'($urandom);
      sent = 0;
      while (sent < n_items) begin
         kind = $urandom_range(0, 9);
         if (kind < 3) begin
            run_len = $urandom_range(1, TABLE_ENTRIES + 2);
            for (int k = 0; k < run_len; k++) send_req(MODE_ADD, pick_id());
         end else if (kind < 5) begin
            run_len = $urandom_range(1, 12);
            for (int k = 0; k < run_len; k++) send_req(MODE_TICK, NODE_ID_W'($urandom));
         end else if (kind < 9) begin
            run_len = $urandom_range(1, 8);
            for (int k = 0; k < run_len; k++) send_req(pick_mode(), pick_id());
         end else begin
            run_len = 1;
            send_req(MODE_W'($urandom_range(MODE_ADD, MODE_UNUSED_HI)), NODE_ID_W'($urandom));
         end
         sent += run_len;
      end
   endtask

   // Main sequence
   initial begin
      reset                 = 1'b1;
      req_bus.valid         = 1'b0;
      req_bus.mode          = MODE_ADD;
      req_bus.node_id       = '0;
      csr_bus.valid         = 1'b0;
      csr_bus.timeout_ticks = TIMEOUT_RESET;
      idle_cycles           = 0;
      burst_left            = 0;
      settings_used         = 1;
      hold_request          = 1'b0;
      timeout_plan = '{16'd1, 16'd65535, 16'd2, 16'd5, 16'd0, 16'd3, 16'd9, 16'd40, 16'd3000};

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      directed_items();
      for (int p = 0; p < PHASE_COUNT; p++) begin
         write_timeout(timeout_plan[p]);
         if (p == HOLD_PHASE) hold_request = 1'b1;
         random_phase(PHASE_ITEMS);
      end

      drain();
      @(negedge clock);
      $display("%0d responses compared over %0d timeout settings, %0d entries aged out by ticks",
               responses_seen, settings_used, aged_out);
      if (failures == 0) begin
         $display("simulation ok");
      end else begin
         $display("%0d mismatches", failures);
         $display("simulation failed");
      end
      $finish;
   end

endmodule

// ----- files.f -----
src/nta_pkg.sv
src/nta_if.sv
src/nta_ctrl.sv
src/nta_dpath.sv
src/neighbor_table_with_aging.sv
bench/nta_table_checker.sv
bench/tb_neighbor_table_with_aging.sv
